// ----- rtl/core/spherical_harmonic_terms_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for spherical_harmonic_terms
// Implication checks sampled on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef SPHERICAL_HARMONIC_TERMS_ASSERT_SVH
`define SPHERICAL_HARMONIC_TERMS_ASSERT_SVH

// antecedent holds -> consequent in the same cycle
`define SHT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sht assertion failed");

// antecedent holds -> consequent in the next cycle
`define SHT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sht assertion failed");

`endif

// ----- rtl/core/sht_pkg.sv -----
// ---------------------------------------------------------------------------
// sht_pkg
// Types, constants and tables of the spherical harmonic term generator.
// ---------------------------------------------------------------------------
package sht_pkg;

  localparam int RadiusW   = 33;
  localparam int LonW      = 29;
  localparam int OrderW    = 6;
  localparam int PowW      = 32;
  localparam int TrigW     = 32;
  localparam int DivW      = 62;
  localparam int CordicN   = 30;
  localparam int AngW      = 38;
  localparam int XyW       = 34;
  localparam int ProdW     = 66;

  localparam logic [RadiusW-1:0] RefRadiusReset = 33'd417543373;
  localparam logic [OrderW-1:0]  MaxOrderReset  = 6'd12;

  localparam logic signed [AngW-1:0] DegHalf    = 38'sd48318382080;
  localparam logic signed [AngW-1:0] DegQuarter = 38'sd24159191040;
  localparam logic signed [AngW-1:0] DegFull    = 38'sd96636764160;
  localparam logic signed [XyW-1:0]  CordicGain = 34'sd652032874;
  localparam logic signed [TrigW-1:0] Q30One    = 32'sd1073741824;
  localparam logic [PowW-1:0]        PowMax     = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    CFG_REF_RADIUS = 2'd0,
    CFG_MAX_ORDER  = 2'd1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_REDUCE,
    ST_FOLD,
    ST_CORDIC,
    ST_SETUP,
    ST_MUL,
    ST_EMIT
  } state_t;

  function automatic logic [34:0] atan_deg(input logic [4:0] i);
    logic [34:0] v;
    unique case (i)
      5'd0:  v = 35'd12079595520;
      5'd1:  v = 35'd7131001626;
      5'd2:  v = 35'd3767825416;
      5'd3:  v = 35'd1912607013;
      5'd4:  v = 35'd960014949;
      5'd5:  v = 35'd480475470;
      5'd6:  v = 35'd240296363;
      5'd7:  v = 35'd120155514;
      5'd8:  v = 35'd60078674;
      5'd9:  v = 35'd30039451;
      5'd10: v = 35'd15019740;
      5'd11: v = 35'd7509872;
      5'd12: v = 35'd3754936;
      5'd13: v = 35'd1877468;
      5'd14: v = 35'd938734;
      5'd15: v = 35'd469367;
      5'd16: v = 35'd234684;
      5'd17: v = 35'd117342;
      5'd18: v = 35'd58671;
      5'd19: v = 35'd29335;
      5'd20: v = 35'd14668;
      5'd21: v = 35'd7334;
      5'd22: v = 35'd3667;
      5'd23: v = 35'd1833;
      5'd24: v = 35'd917;
      5'd25: v = 35'd458;
      5'd26: v = 35'd229;
      5'd27: v = 35'd115;
      5'd28: v = 35'd57;
      5'd29: v = 35'd29;
      default: v = 35'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [TrigW-1:0] clamp_xy(input logic signed [XyW-1:0] v);
    logic signed [TrigW-1:0] r;
    if (v > XyW'(Q30One)) begin
      r = Q30One;
    end else if (v < -XyW'(Q30One)) begin
      r = -Q30One;
    end else begin
      r = v[TrigW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [TrigW-1:0] round_q30(input logic signed [ProdW-1:0] v);
    logic signed [ProdW-1:0] t;
    logic signed [ProdW-31:0] s;
    logic signed [TrigW-1:0] r;
    t = v + ProdW'(64'sd536870912);
    s = t[ProdW-1:30];
    if (s > (ProdW-30)'(Q30One)) begin
      r = Q30One;
    end else if (s < -(ProdW-30)'(Q30One)) begin
      r = -Q30One;
    end else begin
      r = s[TrigW-1:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/sht_channels.sv -----
// ---------------------------------------------------------------------------
// sht channels
// Request and result channels with valid/ready handshake.
// ---------------------------------------------------------------------------
interface sht_in_if;
  import sht_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [RadiusW-1:0]        radius;
  logic signed [LonW-1:0]    longitude;
  modport source (output valid, radius, longitude, input ready);
  modport sink   (input valid, radius, longitude, output ready);
endinterface

interface sht_out_if;
  import sht_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [OrderW-1:0]         degree_index;
  logic [PowW-1:0]           radius_power;
  logic signed [TrigW-1:0]   cos_multiple;
  logic signed [TrigW-1:0]   sin_multiple;
  logic                      saturated;
  logic                      last;
  modport source (output valid, degree_index, radius_power, cos_multiple, sin_multiple,
                  saturated, last, input ready);
  modport sink   (input valid, degree_index, radius_power, cos_multiple, sin_multiple,
                  saturated, last, output ready);
endinterface

// ----- rtl/core/spherical_harmonic_terms.sv -----
// ---------------------------------------------------------------------------
// spherical_harmonic_terms
// Ratio powers and longitude multiples for spherical harmonic synthesis.
//
//   channel   dir  contents
//   in_req    in   radius, longitude
//   out_req   out  degree_index, radius_power, cos/sin_multiple, saturated, last
//   cfg_*     in   reference_radius (index 0), max_order (index 1)
//
// One request passes through the divider, the reduction states, CORDIC and a
// setup state, then for each result through the shared multiplier sequence
// and one load of the output register. Synchronous active-low reset.
// in_req.ready is high only while idle; a stalled result holds the
// sequencer in its load state.
// ---------------------------------------------------------------------------
module spherical_harmonic_terms (
  input  logic                     clk,
  input  logic                     rst_n,
  sht_in_if.sink                   in_req,
  sht_out_if.source                out_req,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [sht_pkg::RadiusW-1:0] cfg_wdata
);
  import sht_pkg::*;

  state_t state_r, state_nxt;

  logic [RadiusW-1:0]        ref_radius_r;
  logic [OrderW-1:0]         max_order_r;
  logic [RadiusW-1:0]        radius_r;
  logic signed [LonW-1:0]    lon_r;
  logic [DivW-1:0]           div_r;
  logic [RadiusW:0]          rem_r;
  logic [5:0]                cnt_r;
  logic [PowW-1:0]           ratio_r;
  logic                      sat_r;
  logic signed [AngW-1:0]    z_r;
  logic                      neg_r;
  logic signed [XyW-1:0]     x_r, y_r;
  logic signed [TrigW-1:0]   cos_step_r, sin_step_r, cos_acc_r, sin_acc_r, cnew_r;
  logic [PowW-1:0]           power_acc_r;
  logic [OrderW-1:0]         n_r;
  logic [2:0]                mstep_r;
  logic signed [ProdW-1:0]   prod_r, acc_r;
  logic                      out_valid_r, out_valid_nxt;
  logic [OrderW-1:0]         out_deg_r;
  logic [PowW-1:0]           out_pow_r;
  logic signed [TrigW-1:0]   out_cos_r, out_sin_r;
  logic                      out_sat_r, out_last_r;

  logic                      in_fire, out_fire, slot_free, emit_load;
  logic [RadiusW:0]          rem_sh;
  logic [RadiusW+1:0]        diff;
  logic signed [AngW-1:0]    ang_a, ang_red;
  logic signed [XyW-1:0]     dx, dy;
  logic signed [AngW-1:0]    atan_ext;
  logic signed [RadiusW-1:0] mul_a, mul_b;
  logic [PowW+4:0]           pow_rnd;
  logic signed [ProdW-1:0]   trig_sum;
  logic signed [TrigW-1:0]   sin_new;

  assign in_req.ready         = (state_r == ST_IDLE);
  assign in_fire              = in_req.valid && in_req.ready;
  assign out_fire             = out_valid_r && out_req.ready;
  assign slot_free            = !out_valid_r || out_req.ready;
  assign emit_load            = (state_r == ST_EMIT) && slot_free;

  assign out_req.valid        = out_valid_r;
  assign out_req.degree_index = out_deg_r;
  assign out_req.radius_power = out_pow_r;
  assign out_req.cos_multiple = out_cos_r;
  assign out_req.sin_multiple = out_sin_r;
  assign out_req.saturated    = out_sat_r;
  assign out_req.last         = out_last_r;

  assign rem_sh   = {rem_r[RadiusW-1:0], div_r[DivW-1]};
  assign diff     = {1'b0, rem_sh} - {2'b00, radius_r};

  assign ang_a    = {lon_r[LonW-1], lon_r, 8'd0};
  assign ang_red  = (ang_a >= DegHalf) ? ang_a - DegFull :
                    (ang_a < -DegHalf) ? ang_a + DegFull : ang_a;

  assign dx       = y_r >>> cnt_r[4:0];
  assign dy       = x_r >>> cnt_r[4:0];
  assign atan_ext = signed'({3'b000, atan_deg(cnt_r[4:0])});

  always_comb begin
    unique case (mstep_r)
      3'd0: begin
        mul_a = signed'({1'b0, power_acc_r});
        mul_b = signed'({1'b0, ratio_r});
      end
      3'd1: begin
        mul_a = RadiusW'(cos_acc_r);
        mul_b = RadiusW'(cos_step_r);
      end
      3'd2: begin
        mul_a = RadiusW'(sin_acc_r);
        mul_b = RadiusW'(sin_step_r);
      end
      3'd3: begin
        mul_a = RadiusW'(cos_acc_r);
        mul_b = RadiusW'(sin_step_r);
      end
      default: begin
        mul_a = RadiusW'(sin_acc_r);
        mul_b = RadiusW'(cos_step_r);
      end
    endcase
  end

  assign pow_rnd  = 37'((prod_r[63:0] + 64'd134217728) >> 28);
  assign trig_sum = (mstep_r == 3'd3) ? acc_r - prod_r : acc_r + prod_r;
  assign sin_new  = round_q30(trig_sum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_fire ? 1'b0 : out_valid_r;
    unique case (state_r)
      ST_IDLE:   if (in_fire) state_nxt = ST_DIV;
      ST_DIV:    if (cnt_r == 6'(DivW - 1)) state_nxt = ST_REDUCE;
      ST_REDUCE: state_nxt = ST_FOLD;
      ST_FOLD:   state_nxt = ST_CORDIC;
      ST_CORDIC: if (cnt_r == 6'(CordicN - 1)) state_nxt = ST_SETUP;
      ST_SETUP:  state_nxt = ST_MUL;
      ST_MUL:    if (mstep_r == 3'd5) state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = (n_r == max_order_r) ? ST_IDLE : ST_MUL;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_radius_r <= RefRadiusReset;
      max_order_r  <= MaxOrderReset;
    end else if (cfg_we) begin
      if (cfg_index == CFG_REF_RADIUS) ref_radius_r <= cfg_wdata;
      if (cfg_index == CFG_MAX_ORDER)  max_order_r  <= cfg_wdata[OrderW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      mstep_r     <= '0;
      n_r         <= '0;
      sat_r       <= 1'b0;
      neg_r       <= 1'b0;
      ratio_r     <= '0;
      power_acc_r <= '0;
      cos_step_r  <= '0;
      sin_step_r  <= '0;
      cos_acc_r   <= Q30One;
      sin_acc_r   <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            radius_r <= in_req.radius;
            lon_r    <= in_req.longitude;
            div_r    <= DivW'({ref_radius_r, 28'd0}) + DivW'(in_req.radius[RadiusW-1:1]);
            rem_r    <= '0;
            cnt_r    <= '0;
          end
        end
        ST_DIV: begin
          cnt_r <= cnt_r + 6'd1;
          if (!diff[RadiusW+1]) begin
            rem_r <= diff[RadiusW:0];
            div_r <= {div_r[DivW-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            div_r <= {div_r[DivW-2:0], 1'b0};
          end
        end
        ST_REDUCE: begin
          z_r <= ang_red;
          if (|div_r[DivW-1:PowW]) begin
            ratio_r <= PowMax;
            sat_r   <= 1'b1;
          end else begin
            ratio_r <= div_r[PowW-1:0];
            sat_r   <= 1'b0;
          end
        end
        ST_FOLD: begin
          x_r   <= CordicGain;
          y_r   <= '0;
          cnt_r <= '0;
          if (z_r > DegQuarter) begin
            z_r   <= z_r - DegHalf;
            neg_r <= 1'b1;
          end else if (z_r < -DegQuarter) begin
            z_r   <= z_r + DegHalf;
            neg_r <= 1'b1;
          end else begin
            neg_r <= 1'b0;
          end
        end
        ST_CORDIC: begin
          cnt_r <= cnt_r + 6'd1;
          if (!z_r[AngW-1]) begin
            x_r <= x_r - dx;
            y_r <= y_r + dy;
            z_r <= z_r - atan_ext;
          end else begin
            x_r <= x_r + dx;
            y_r <= y_r - dy;
            z_r <= z_r + atan_ext;
          end
        end
        ST_SETUP: begin
          cos_step_r  <= neg_r ? -clamp_xy(x_r) : clamp_xy(x_r);
          sin_step_r  <= neg_r ? -clamp_xy(y_r) : clamp_xy(y_r);
          power_acc_r <= ratio_r;
          cos_acc_r   <= Q30One;
          sin_acc_r   <= '0;
          n_r         <= '0;
          mstep_r     <= '0;
        end
        ST_MUL: begin
          mstep_r <= mstep_r + 3'd1;
          prod_r  <= mul_a * mul_b;
          unique case (mstep_r)
            3'd1: begin
              if (sat_r || (|pow_rnd[PowW+4:PowW])) begin
                power_acc_r <= PowMax;
                sat_r       <= 1'b1;
              end else begin
                power_acc_r <= pow_rnd[PowW-1:0];
              end
            end
            3'd2: acc_r  <= prod_r;
            3'd3: cnew_r <= round_q30(trig_sum);
            3'd4: acc_r  <= prod_r;
            3'd5: begin
              mstep_r <= '0;
              if (n_r != '0) begin
                cos_acc_r <= cnew_r;
                sin_acc_r <= sin_new;
              end
            end
            default: ;
          endcase
        end
        ST_EMIT: begin
          if (slot_free) begin
            out_deg_r  <= n_r;
            out_pow_r  <= power_acc_r;
            out_cos_r  <= cos_acc_r;
            out_sin_r  <= sin_acc_r;
            out_sat_r  <= sat_r;
            out_last_r <= (n_r == max_order_r);
            n_r        <= n_r + 6'd1;
          end
        end
        default: ;
      endcase
    end
  end

`include "spherical_harmonic_terms_assert.svh"

  `SHT_ASSERT_NEXT(a_accept_starts_div, in_fire, state_r == ST_DIV)
  `SHT_ASSERT_NEXT(a_last_returns_idle, emit_load && (n_r == max_order_r), state_r == ST_IDLE)
  `SHT_ASSERT_SAME(a_last_degree, out_valid_r && out_last_r, out_deg_r == max_order_r)
  `SHT_ASSERT_SAME(a_cos_range, 1'b1, (cos_acc_r <= Q30One) && (cos_acc_r >= -Q30One))

endmodule

// ----- sim/testbench.sv -----
// ---------------------------------------------------------------------------
// testbench
// Drives radius/longitude requests into spherical_harmonic_terms under
// several configurations and handshake idling patterns, predicts every
// term (ratio power, cos/sin multiple, flags) in fixed point and compares
// each result against the oldest pending prediction.
// ---------------------------------------------------------------------------
module testbench;
  import sht_pkg::*;

  localparam int     WatchLimit = 20000;
  localparam longint Q30       = 64'sd1073741824;
  localparam longint PowTop    = 64'hFFFF_FFFF;
  localparam longint HalfTurn  = 64'sd48318382080;
  localparam longint QtrTurn   = 64'sd24159191040;
  localparam longint FullTurn  = 64'sd96636764160;
  localparam longint InvGain   = 64'sd652032874;
  localparam longint RadiusTop = 64'sd6553600000;
  localparam longint ArcTab [30] = '{
    64'sd12079595520, 64'sd7131001626, 64'sd3767825416, 1912607013, 960014949,
    480475470, 240296363, 120155514, 60078674, 30039451,
    15019740, 7509872, 3754936, 1877468, 938734,
    469367, 234684, 117342, 58671, 29335,
    14668, 7334, 3667, 1833, 917,
    458, 229, 115, 57, 29};

  typedef struct packed {
    logic [RadiusW-1:0]     radius;
    logic signed [LonW-1:0] longitude;
  } request_t;

  typedef struct packed {
    logic [OrderW-1:0] degree_index;
    logic [PowW-1:0]   radius_power;
    logic [TrigW-1:0]  cos_multiple;
    logic [TrigW-1:0]  sin_multiple;
    logic              saturated;
    logic              last;
  } term_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [RadiusW-1:0] cfg_wdata;

  sht_in_if  in_ch ();
  sht_out_if out_ch ();

  spherical_harmonic_terms dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (in_ch.sink),
    .out_req  (out_ch.source),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  request_t pending_reqs [$];
  term_t    expected_terms [$];
  longint   ref_radius_q;
  int       max_order_q;
  int       idle_mode;
  int       mismatches;
  int       quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint clamp_unit(longint v);
    if (v > Q30) return Q30;
    if (v < -Q30) return -Q30;
    return v;
  endfunction

  function automatic longint mul_power(longint a, longint b, inout bit clip);
    logic [63:0] r;
    r = (64'(a) * 64'(b) + 64'd134217728) >> 28;
    if (r > 64'(PowTop)) begin
      clip = 1'b1;
      return PowTop;
    end
    return longint'(r);
  endfunction

  function automatic bit idle_draw(bit sender);
    case (idle_mode)
      1: return sender && ($urandom_range(0, 99) < 81);
      2: return !sender && ($urandom_range(0, 99) < 81);
      3: return $urandom_range(0, 99) < 9;
      default: return 1'b0;
    endcase
  endfunction

  task automatic predict_terms(request_t req);
    logic [63:0] quot;
    longint lon, ang, m, x, y, z, dx, dy, c_step, s_step, pw, c_acc, s_acc, c, s;
    bit clip, flip;
    term_t t;
    lon = longint'(req.longitude);
    clip = 1'b0;
    if (req.radius == 0) begin
      quot = 64'(PowTop);
      clip = 1'b1;
    end else begin
      quot = ((64'(ref_radius_q) << 28) + (64'(req.radius) >> 1)) / 64'(req.radius);
      if (quot > 64'(PowTop)) begin
        quot = 64'(PowTop);
        clip = 1'b1;
      end
    end
    m = (lon * 256 + HalfTurn) % FullTurn;
    if (m < 0) m += FullTurn;
    ang = m - HalfTurn;
    flip = 1'b0;
    if (ang > QtrTurn) begin
      ang -= HalfTurn;
      flip = 1'b1;
    end else if (ang < -QtrTurn) begin
      ang += HalfTurn;
      flip = 1'b1;
    end
    x = InvGain;
    y = 0;
    z = ang;
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ArcTab[i];
      end else begin
        x += dx; y -= dy; z += ArcTab[i];
      end
    end
    c_step = clamp_unit(x);
    s_step = clamp_unit(y);
    if (flip) begin
      c_step = -c_step;
      s_step = -s_step;
    end
    pw = mul_power(longint'(quot), longint'(quot), clip);
    if (clip) pw = PowTop;
    c_acc = Q30;
    s_acc = 0;
    for (int n = 0; n <= max_order_q; n++) begin
      if (n > 0) begin
        pw = clip ? PowTop : mul_power(pw, longint'(quot), clip);
        c = c_acc * c_step - s_acc * s_step;
        s = c_acc * s_step + s_acc * c_step;
        c_acc = clamp_unit((c + 64'sd536870912) >>> 30);
        s_acc = clamp_unit((s + 64'sd536870912) >>> 30);
      end
      t.degree_index = OrderW'(n);
      t.radius_power = pw[31:0];
      t.cos_multiple = c_acc[31:0];
      t.sin_multiple = s_acc[31:0];
      t.saturated    = clip;
      t.last         = (n == max_order_q);
      expected_terms.push_back(t);
    end
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0h want %0h", what, got, want);
    mismatches++;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.radius <= '0;
      in_ch.longitude <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) predict_terms('{in_ch.radius, in_ch.longitude});
      if (pending_reqs.size() > 0 && !idle_draw(1'b1)) begin
        in_ch.radius <= pending_reqs[0].radius;
        in_ch.longitude <= pending_reqs[0].longitude;
        void'(pending_reqs.pop_front());
        in_ch.valid <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    term_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_terms.size() == 0) begin
          report_mismatch("unexpected result", out_ch.degree_index, 0);
        end else begin
          want = expected_terms.pop_front();
          if (out_ch.degree_index !== want.degree_index)
            report_mismatch("degree_index", out_ch.degree_index, want.degree_index);
          if (out_ch.radius_power !== want.radius_power)
            report_mismatch("radius_power", out_ch.radius_power, want.radius_power);
          if (out_ch.cos_multiple !== want.cos_multiple)
            report_mismatch("cos_multiple", out_ch.cos_multiple, want.cos_multiple);
          if (out_ch.sin_multiple !== want.sin_multiple)
            report_mismatch("sin_multiple", out_ch.sin_multiple, want.sin_multiple);
          if (out_ch.saturated !== want.saturated)
            report_mismatch("saturated", out_ch.saturated, want.saturated);
          if (out_ch.last !== want.last)
            report_mismatch("last", out_ch.last, want.last);
        end
      end
      out_ch.ready <= !idle_draw(1'b0);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_ch.valid || expected_terms.size() > 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [RadiusW-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_REF_RADIUS) ref_radius_q = longint'(value);
    else max_order_q = int'(value);
  endtask

  task automatic add_req(longint radius, longint lon);
    pending_reqs.push_back('{RadiusW'(radius), LonW'(lon)});
  endtask

  task automatic add_random_req();
    longint r, lon;
    if ($urandom_range(0, 9) < 8)
      r = ref_radius_q * longint'($urandom_range(60, 160)) / 100;
    else
      r = {31'd0, 1'($urandom), $urandom};
    if ($urandom_range(0, 9) < 8)
      lon = longint'($urandom_range(0, 377487360)) - 188743680;
    else
      lon = longint'(signed'(LonW'($urandom)));
    add_req(r, lon);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_REF_RADIUS;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.radius = '0;
    in_ch.longitude = '0;
    out_ch.ready = 1'b0;
    ref_radius_q = 417543373;
    max_order_q = 12;
    idle_mode = 0;
    mismatches = 0;
    quiet_cycles = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    add_req(417543373, 0);
    add_req(0, 94371840);
    add_req(1, -94371840);
    add_req(64'h1_FFFF_FFFF, 188743680);
    add_req(65536, -188743680);
    add_req(RadiusTop, 47185920);
    add_req(300000000, -268435456);
    add_req(500000000, 268435455);
    add_req(417543373, 209715200);
    add_req(417543374, -209715200);
    add_req(400000000, 1);
    add_req(450000000, -1);
    wait_drained();

    write_reg(CFG_REF_RADIUS, RadiusW'(RadiusTop));
    write_reg(CFG_MAX_ORDER, 0);
    add_req(65536, 31457280);
    add_req(RadiusTop, -31457280);
    add_req(64'h1_FFFF_FFFF, 140000000);
    wait_drained();

    write_reg(CFG_REF_RADIUS, 65536);
    write_reg(CFG_MAX_ORDER, 63);
    add_req(65536, 11000000);
    add_req(RadiusTop, -77000000);
    add_req(131072, 150000000);
    wait_drained();

    write_reg(CFG_REF_RADIUS, 417543373);
    write_reg(CFG_MAX_ORDER, 63);
    add_req(420000000, 12345678);
    add_req(410000000, -187654321);
    wait_drained();

    for (int chunk = 0; chunk < 6; chunk++) begin
      idle_mode = chunk % 4;
      if ($urandom_range(0, 3) == 0)
        write_reg(CFG_REF_RADIUS, $urandom_range(0, 1) ? 33'd65536 : RadiusW'(RadiusTop));
      else
        write_reg(CFG_REF_RADIUS, 417543373 + $urandom_range(0, 20000000) - 10000000);
      write_reg(CFG_MAX_ORDER, (chunk == 5) ? 63 : $urandom_range(0, 8));
      for (int k = 0; k < 25; k++) add_random_req();
      wait_drained();
    end

    repeat (600) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/sht_pkg.sv
rtl/core/sht_channels.sv
rtl/core/spherical_harmonic_terms.sv
sim/testbench.sv
